// ===== rtl/core/camera_package_deframer_assert.svh =====
// assertion macros shared by the deframer rtl
`ifndef CAMERA_PACKAGE_DEFRAMER_ASSERT_SVH
`define CAMERA_PACKAGE_DEFRAMER_ASSERT_SVH
`ifndef SYNTHESIS
`define CPD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("cpd assertion failed");
`define CPD_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error("cpd forbidden condition seen");
`else
`define CPD_ASSERT(lbl, clk, rst_n, prop)
`define CPD_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== rtl/core/cpd_pkg.sv =====
// types and constants of the camera package deframer
package cpd_pkg;

	typedef enum logic [2:0] {
		PH_ID0  = 3'd0,
		PH_ID1  = 3'd1,
		PH_SZ0  = 3'd2,
		PH_SZ1  = 3'd3,
		PH_DATA = 3'd4,
		PH_CK0  = 3'd5,
		PH_CK1  = 3'd6
	} phase_t;

	localparam logic [1:0] KIND_DATA    = 2'd0;
	localparam logic [1:0] KIND_END     = 2'd1;
	localparam logic [1:0] KIND_REFUSAL = 2'd2;

	localparam logic CFG_IMAGE_LENGTH = 1'b0;
	localparam logic CFG_CHECK_ENABLE = 1'b1;

	localparam int TOTAL_W = 24;
	localparam int ID_W    = 16;

	localparam logic [7:0]         REFUSE_B0     = 8'hAA;
	localparam logic [7:0]         REFUSE_B1     = 8'h0F;
	localparam logic [7:0]         LAST_ACK_BYTE = 8'hF0;
	localparam logic [ID_W-1:0]    LAST_ACK      = {LAST_ACK_BYTE, LAST_ACK_BYTE};
	localparam logic [TOTAL_W-1:0] TOTAL_MAX     = {TOTAL_W{1'b1}};

	typedef struct packed {
		logic [TOTAL_W-1:0] image_length;
		logic               check_enable;
	} cfg_t;

	typedef struct packed {
		logic            valid;
		logic [1:0]      kind;
		logic [7:0]      data_byte;
		logic [ID_W-1:0] package_id;
		logic [ID_W-1:0] ack_id;
		logic            checksum_ok;
		logic            last_package;
	} res_t;

endpackage

// ===== rtl/core/camera_package_deframer.sv =====
// top level of the camera package deframer
// path: a word is taken into the input register at its accepting edge; the parser steps on it
// once the output register can take a result word, and its result word, if any, is loaded there
// throughput: one word per cycle while the output is not stalled; the parser step is the only loop
// reset: arst_n clears the parser to the first id byte, zeroes the totals and
// empties both registers; image_length resets to 0, check_enable to 1
`include "camera_package_deframer_assert.svh"
module camera_package_deframer
	import cpd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// configuration write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [TOTAL_W-1:0] cfg_data,
	// receive byte channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         kind,
	output logic [7:0]         data_byte,
	output logic [ID_W-1:0]    package_id,
	output logic [ID_W-1:0]    ack_id,
	output logic               checksum_ok,
	output logic               last_package
);

	cfg_t       cfg;
	res_t       step_res;
	res_t       out_res;
	logic       stall;
	logic       step;
	logic       valid_s1;
	logic [7:0] rx_byte_s1;

	// config writes must only be issued while idle (the user's duty, not enforced here); they are always taken
	assign cfg_ready = 1'b1;

	cpd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en_i (cfg_valid && cfg_ready),
		.index_i (cfg_index),
		.data_i  (cfg_data),
		.cfg_o   (cfg)
	);

	// the parser consumes the staged word whenever the output register can
	// take a result word this cycle (empty, or being drained)
	assign step     = valid_s1 && !stall;
	assign in_ready = !valid_s1 || !stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			rx_byte_s1 <= rx_byte;
	end

	cpd_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step_i (step),
		.byte_i (rx_byte_s1),
		.cfg_i  (cfg),
		.res_o  (step_res)
	);

	// result register decouples the parser from the downstream ready
	cpd_result_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load_i  (step && step_res.valid),
		.res_i   (step_res),
		.ready_i (out_ready),
		.stall_o (stall),
		.res_o   (out_res)
	);

	assign out_valid    = out_res.valid;
	assign kind         = out_res.kind;
	assign data_byte    = out_res.data_byte;
	assign package_id   = out_res.package_id;
	assign ack_id       = out_res.ack_id;
	assign checksum_ok  = out_res.checksum_ok;
	assign last_package = out_res.last_package;

	// a staged word held back by a stalled output must stay put
	`CPD_ASSERT(a_stage_holds, clk, arst_n, valid_s1 && stall |=> valid_s1 && $stable(rx_byte_s1))
	`CPD_ASSERT_NEVER(a_step_when_stalled, clk, arst_n, step && stall)

endmodule

// ===== rtl/core/cpd_cfg_regs.sv =====
// configuration registers of the deframer
module cpd_cfg_regs
	import cpd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en_i,
	input  logic               index_i,
	input  logic [TOTAL_W-1:0] data_i,
	output cfg_t               cfg_o
);

	logic [TOTAL_W-1:0] image_length_q;
	logic               check_enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_length_q <= '0;
			check_enable_q <= 1'b1;
		end else if (wr_en_i) begin
			unique case (index_i)
				CFG_IMAGE_LENGTH: image_length_q <= data_i;
				CFG_CHECK_ENABLE: check_enable_q <= data_i[0];
				default: ;
			endcase
		end
	end

	assign cfg_o.image_length = image_length_q;
	assign cfg_o.check_enable = check_enable_q;

endmodule

// ===== rtl/core/cpd_parser.sv =====
// byte parser: package phases, running checksum and image byte total
`include "camera_package_deframer_assert.svh"
module cpd_parser
	import cpd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step_i,
	input  logic [7:0] byte_i,
	input  cfg_t       cfg_i,
	output res_t       res_o
);

	phase_t             phase_q, phase_d;
	logic [ID_W-1:0]    id_q, id_d;
	logic [7:0]         size_lo_q, size_lo_d;
	logic [15:0]        left_q, left_d;
	logic [7:0]         sum_q, sum_d;
	logic [7:0]         ck_q, ck_d;
	logic [TOTAL_W-1:0] total_q, total_d;
	logic               refusal;
	logic [15:0]        left_dec;
	logic [15:0]        size_full;
	logic               last;
	logic               ok;

	assign refusal   = (id_q[7:0] == REFUSE_B0) && (id_q[15:8] == REFUSE_B1);
	assign left_dec  = left_q - 16'd1;
	assign size_full = {byte_i, size_lo_q};
	assign last      = total_q >= cfg_i.image_length;
	assign ok        = !cfg_i.check_enable || (sum_q == ck_q);

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_ID1:  phase_d = PH_SZ0;
			PH_SZ0:  phase_d = PH_SZ1;
			PH_SZ1: begin
				if (refusal)
					phase_d = PH_ID0;
				else if (size_full == '0)
					phase_d = PH_CK0;
				else
					phase_d = PH_DATA;
			end
			PH_DATA: phase_d = (left_dec == '0) ? PH_CK0 : PH_DATA;
			PH_CK0:  phase_d = PH_CK1;
			PH_CK1:  phase_d = PH_ID0;
			default: phase_d = PH_ID1;
		endcase
	end

	// datapath updates and result word
	always_comb begin
		id_d      = id_q;
		size_lo_d = size_lo_q;
		left_d    = left_q;
		sum_d     = sum_q + byte_i;
		ck_d      = ck_q;
		total_d   = total_q;
		res_o     = '0;
		unique case (phase_q)
			PH_ID1: id_d[15:8] = byte_i;
			PH_SZ0: size_lo_d = byte_i;
			PH_SZ1: begin
				if (refusal) begin
					total_d          = '0;
					res_o.valid      = 1'b1;
					res_o.kind       = KIND_REFUSAL;
					res_o.package_id = id_q;
				end else begin
					left_d = size_full;
				end
			end
			PH_DATA: begin
				left_d = left_dec;
				if (total_q != TOTAL_MAX)
					total_d = total_q + 1'b1;
				res_o.valid     = 1'b1;
				res_o.kind      = KIND_DATA;
				res_o.data_byte = byte_i;
			end
			PH_CK0: begin
				ck_d  = byte_i;
				sum_d = sum_q;
			end
			PH_CK1: begin
				sum_d = sum_q;
				if (last)
					total_d = '0;
				res_o.valid        = 1'b1;
				res_o.kind         = KIND_END;
				res_o.package_id   = id_q;
				res_o.ack_id       = last ? LAST_ACK : id_q;
				res_o.checksum_ok  = ok;
				res_o.last_package = last;
			end
			default: begin
				// first id byte, also taken for unused phase codes
				id_d   = {8'd0, byte_i};
				sum_d  = byte_i;
				left_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_ID0;
			id_q      <= '0;
			size_lo_q <= '0;
			left_q    <= '0;
			sum_q     <= '0;
			ck_q      <= '0;
			total_q   <= '0;
		end else if (step_i) begin
			phase_q   <= phase_d;
			id_q      <= id_d;
			size_lo_q <= size_lo_d;
			left_q    <= left_d;
			sum_q     <= sum_d;
			ck_q      <= ck_d;
			total_q   <= total_d;
		end
	end

	`CPD_ASSERT(a_end_returns_idle, clk, arst_n, step_i && phase_q == PH_CK1 |=> phase_q == PH_ID0)
	`CPD_ASSERT(a_data_runs_out, clk, arst_n, step_i && phase_q == PH_DATA && left_q == 16'd1 |=> phase_q == PH_CK0)
	`CPD_ASSERT_NEVER(a_data_outside_phase, clk, arst_n, res_o.valid && res_o.kind == KIND_DATA && phase_q != PH_DATA)

endmodule

// ===== rtl/core/cpd_result_reg.sv =====
// output register holding one result word until it is taken
module cpd_result_reg
	import cpd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic load_i,
	input  res_t res_i,
	input  logic ready_i,
	output logic stall_o,
	output res_t res_o
);

	logic valid_q;
	res_t res_q;

	assign stall_o = valid_q && !ready_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load_i)
			valid_q <= 1'b1;
		else if (ready_i)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_i)
			res_q <= res_i;
	end

	always_comb begin
		res_o       = res_q;
		res_o.valid = valid_q;
	end

endmodule
